>>> rtl/core/clnws_pkg.sv
`default_nettype none

package clnws_pkg;

    // Fixed field widths
    localparam int OPCODE_W = 3;
    localparam int BYTE_W   = 8;
    localparam int NIB_W    = 4;
    localparam int COLUMN_W = 5;
    localparam int ROW_W    = 2;
    localparam int WAIT_W   = 17;

    // Back-end step counter (init script is the longest job: 15 steps)
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] INIT_LAST_STEP  = 4'd14;
    localparam logic [STEP_W-1:0] INIT_BYTE_START = 4'd5;
    localparam logic [STEP_W-1:0] WAKE_LAST_STEP  = 4'd3;
    localparam logic [STEP_W-1:0] MODE_STEP       = 4'd4;
    localparam logic [STEP_W-1:0] BYTES_LAST_STEP = 4'd3;
    localparam logic [STEP_W-1:0] MAIN_ONLY_START = 4'd2;

    // Job queue depth
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Defaults
    localparam int LINE_WIDTH_DEFAULT = 16;
    localparam logic [BYTE_W-1:0] CTRL_RESET = 8'h0C;

    // Wait times in microseconds
    localparam logic [WAIT_W-1:0] WAIT_POWERUP = 17'd100000;
    localparam logic [WAIT_W-1:0] WAIT_CMD     = 17'd5000;
    localparam logic [WAIT_W-1:0] WAIT_DATA    = 17'd50;
    localparam logic [WAIT_W-1:0] WAIT_NONE    = 17'd0;

    // LCD command bytes and nibbles
    localparam logic [NIB_W-1:0]  NIB_WAKE      = 4'h3;
    localparam logic [NIB_W-1:0]  NIB_BUS4      = 4'h2;
    localparam logic [BYTE_W-1:0] CMD_FUNC_SET  = 8'h28;
    localparam logic [BYTE_W-1:0] CMD_DISP_OFF  = 8'h08;
    localparam logic [BYTE_W-1:0] CMD_CLEAR     = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_ENTRY     = 8'h06;
    localparam logic [BYTE_W-1:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_LINE2     = 8'hC0;
    localparam logic [BYTE_W-1:0] ROW1_BITS     = 8'h40;
    localparam logic [BYTE_W-1:0] ROW2_BITS     = 8'h60;
    localparam logic [BYTE_W-1:0] ROW3_BITS     = 8'h20;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INIT   = 3'd0,
        OP_CMD    = 3'd1,
        OP_DATA   = 3'd2,
        OP_CURSOR = 3'd3,
        OP_STRING = 3'd4
    } opcode_t;

    typedef enum logic {
        RS_INSTR = 1'b0,
        RS_DATA  = 1'b1
    } rs_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [BYTE_W-1:0]   value;
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row;
        logic                first_of_string;
    } in_item_t;

    typedef struct packed {
        logic [NIB_W-1:0]  nibble;
        logic              reg_select;
        logic              strobe_res;
        logic [WAIT_W-1:0] wait_us;
        logic              last;
    } out_item_t;

    // Work unit passed from front to back
    typedef struct packed {
        logic              init;      // play power-up script
        logic              has_pre;   // send pre_byte as a command first
        logic [BYTE_W-1:0] pre_byte;
        logic [BYTE_W-1:0] main_byte;
        rs_t               main_rs;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [BYTE_W-1:0] row_bits(input logic [ROW_W-1:0] row);
        logic [BYTE_W-1:0] r;
        case (row)
            2'd1:    r = ROW1_BITS;
            2'd2:    r = ROW2_BITS;
            2'd3:    r = ROW3_BITS;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] init_byte(input logic [2:0] idx,
                                                    input logic [BYTE_W-1:0] ctrl);
        logic [BYTE_W-1:0] b;
        case (idx)
            3'd0:    b = CMD_FUNC_SET;
            3'd1:    b = CMD_DISP_OFF;
            3'd2:    b = CMD_CLEAR;
            3'd3:    b = CMD_ENTRY;
            default: b = ctrl;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/clnws_front.sv
`default_nettype none

module clnws_front #(
    parameter int LINE_WIDTH = clnws_pkg::LINE_WIDTH_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire clnws_pkg::in_item_t in_data,
    input  wire clnws_pkg::q_stat_t  q_stat,
    output logic                     push,
    output clnws_pkg::job_t          job
);

    localparam int COL_W = $clog2(LINE_WIDTH + 1);
    localparam logic [COL_W-1:0] LINE_END = COL_W'(LINE_WIDTH);

    logic [COL_W-1:0] col_reg, col_next, col_eff;
    logic             row_reg, row_next, row_eff;
    logic             stop_reg, stop_next, stop_eff;
    logic             job_valid;
    logic             accept;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && job_valid;

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        stop_next = stop_reg;
        job_valid = 1'b0;
        job       = '0;
        job.main_byte = in_data.value;
        job.main_rs   = clnws_pkg::RS_INSTR;

        // string cursor as seen after an optional restart at home
        col_eff  = in_data.first_of_string ? '0 : col_reg;
        row_eff  = in_data.first_of_string ? 1'b0 : row_reg;
        stop_eff = in_data.first_of_string ? 1'b0 : stop_reg;

        case (in_data.opcode)
            clnws_pkg::OP_INIT:
            begin
                job.init  = 1'b1;
                job_valid = 1'b1;
            end
            clnws_pkg::OP_CMD:
            begin
                job_valid = 1'b1;
            end
            clnws_pkg::OP_DATA:
            begin
                job.main_rs = clnws_pkg::RS_DATA;
                job_valid   = 1'b1;
            end
            clnws_pkg::OP_CURSOR:
            begin
                if (32'(in_data.column) < 32'(LINE_WIDTH))
                begin
                    job.main_byte = clnws_pkg::CMD_SET_DDRAM
                                  | clnws_pkg::BYTE_W'(in_data.column)
                                  | clnws_pkg::row_bits(in_data.row);
                    job_valid     = 1'b1;
                end
            end
            clnws_pkg::OP_STRING:
            begin
                job.has_pre  = in_data.first_of_string;
                job.pre_byte = clnws_pkg::CMD_SET_DDRAM;
                job.main_rs  = clnws_pkg::RS_DATA;
                col_next     = col_eff;
                row_next     = row_eff;
                stop_next    = stop_eff;
                if (!stop_eff)
                begin
                    if (col_eff == LINE_END)
                    begin
                        if (!row_eff)
                        begin
                            // wrap to line two, then place the char at column 0
                            job.has_pre  = 1'b1;
                            job.pre_byte = clnws_pkg::CMD_LINE2;
                            job_valid    = 1'b1;
                            row_next     = 1'b1;
                            col_next     = COL_W'(1);
                        end
                        else
                        begin
                            stop_next = 1'b1;
                        end
                    end
                    else
                    begin
                        job_valid = 1'b1;
                        col_next  = col_eff + 1'b1;
                    end
                end
                else
                begin
                    // home command alone never happens: a restart clears stop
                    job_valid = job.has_pre;
                end
            end
            default:
            begin
                job_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= 1'b0;
            stop_reg <= 1'b0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            stop_reg <= stop_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/clnws_queue.sv
`default_nettype none

module clnws_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire clnws_pkg::job_t    push_job,
    input  wire logic               pop,
    output clnws_pkg::job_t         head,
    output clnws_pkg::q_stat_t      q_stat
);

    clnws_pkg::job_t entry_reg [clnws_pkg::QUEUE_DEPTH];

    logic [clnws_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [clnws_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [clnws_pkg::QCNT_W-1:0] count_reg, count_next;

    function automatic logic [clnws_pkg::QPTR_W-1:0] ptr_inc(
        input logic [clnws_pkg::QPTR_W-1:0] p);
        logic [clnws_pkg::QPTR_W-1:0] r;
        if (32'(p) == clnws_pkg::QUEUE_DEPTH - 1)
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == clnws_pkg::QCNT_W'(clnws_pkg::QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

>>> rtl/core/clnws_back.sv
`default_nettype none

module clnws_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire clnws_pkg::job_t               head,
    input  wire clnws_pkg::q_stat_t            q_stat,
    output logic                               pop,
    input  wire logic [clnws_pkg::BYTE_W-1:0]  ctrl_byte,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output clnws_pkg::out_item_t               out_data
);

    logic [clnws_pkg::STEP_W-1:0] step_reg, step_next;
    logic [clnws_pkg::STEP_W-1:0] eff_step;
    logic [clnws_pkg::STEP_W-1:0] init_k;
    logic [clnws_pkg::BYTE_W-1:0] cur_byte;
    logic                         out_valid_reg, out_valid_next;
    clnws_pkg::out_item_t         out_data_reg, out_data_next;
    clnws_pkg::out_item_t         step_item;
    logic                         load;

    assign load     = !q_stat.empty && (!out_valid_reg || out_ready);
    assign eff_step = head.init ? step_reg
                    : step_reg + (head.has_pre ? '0 : clnws_pkg::MAIN_ONLY_START);
    assign init_k   = step_reg - clnws_pkg::INIT_BYTE_START;

    // Decode the current step of the head job into one pin-level result
    always_comb
    begin
        step_item            = '0;
        step_item.strobe_res = 1'b1;
        cur_byte             = '0;
        if (head.init)
        begin
            step_item.last = (step_reg == clnws_pkg::INIT_LAST_STEP);
            if (step_reg == '0)
            begin
                step_item.strobe_res = 1'b0;
                step_item.wait_us    = clnws_pkg::WAIT_POWERUP;
            end
            else if (step_reg <= clnws_pkg::WAKE_LAST_STEP)
            begin
                step_item.nibble  = clnws_pkg::NIB_WAKE;
                step_item.wait_us = clnws_pkg::WAIT_CMD;
            end
            else if (step_reg == clnws_pkg::MODE_STEP)
            begin
                step_item.nibble  = clnws_pkg::NIB_BUS4;
                step_item.wait_us = clnws_pkg::WAIT_CMD;
            end
            else
            begin
                cur_byte          = clnws_pkg::init_byte(init_k[3:1], ctrl_byte);
                step_item.nibble  = init_k[0] ? cur_byte[3:0] : cur_byte[7:4];
                step_item.wait_us = init_k[0] ? clnws_pkg::WAIT_CMD
                                              : clnws_pkg::WAIT_NONE;
            end
        end
        else
        begin
            step_item.last       = (eff_step == clnws_pkg::BYTES_LAST_STEP);
            cur_byte             = eff_step[1] ? head.main_byte : head.pre_byte;
            step_item.reg_select = eff_step[1] ? head.main_rs : clnws_pkg::RS_INSTR;
            step_item.nibble     = eff_step[0] ? cur_byte[3:0] : cur_byte[7:4];
            if (!eff_step[0])
                step_item.wait_us = clnws_pkg::WAIT_NONE;
            else if (step_item.reg_select == clnws_pkg::RS_DATA)
                step_item.wait_us = clnws_pkg::WAIT_DATA;
            else
                step_item.wait_us = clnws_pkg::WAIT_CMD;
        end
    end

    always_comb
    begin
        pop            = load && step_item.last;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load)
        begin
            step_next      = step_item.last ? '0 : step_reg + 1'b1;
            out_valid_next = 1'b1;
            out_data_next  = step_item;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/char_lcd_nibble_write_sequencer.sv
`default_nettype none

// Channel | Direction | Handshake            | Payload
// --------+-----------+----------------------+--------------------------------
// in      | input     | in_valid / in_ready  | in_data  (clnws_pkg::in_item_t)
// out     | output    | out_valid / out_ready| out_data (clnws_pkg::out_item_t)
// cfg     | input     | cfg_we (no wait)     | cfg_wdata (display control byte)
//
// Cycles: the back end emits one LCD step per cycle while out_ready is high,
// through the single output register. An init request has 15 steps, a byte
// request 2 or 4; a request that makes no steps pushes no job.
// Reset: rst_n async low; clears string cursor, queue and output valid; the
// display control register returns to 0x0C.
// Stalls: a 2-entry job queue parts front and back; in_ready drops only when it
// is full, so new transactions are taken while results wait on out_ready.

module char_lcd_nibble_write_sequencer #(
    parameter int LINE_WIDTH = clnws_pkg::LINE_WIDTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire clnws_pkg::in_item_t           in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output clnws_pkg::out_item_t               out_data,
    input  wire logic                          cfg_we,
    input  wire logic [clnws_pkg::BYTE_W-1:0]  cfg_wdata
);

    // Display control byte: last command of the init script
    logic [clnws_pkg::BYTE_W-1:0] ctrl_reg, ctrl_next;

    clnws_pkg::job_t    push_job;
    clnws_pkg::job_t    head_job;
    clnws_pkg::q_stat_t q_stat;
    logic               q_push;
    logic               q_pop;

    assign ctrl_next = cfg_we ? cfg_wdata : ctrl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= clnws_pkg::CTRL_RESET;
        else
            ctrl_reg <= ctrl_next;
    end

    // Front: classify each transaction, track string cursor, build a job
    clnws_front #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_stat   (q_stat),
        .push     (q_push),
        .job      (push_job)
    );

    // Short job queue so front and back stall independently
    clnws_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head     (head_job),
        .q_stat   (q_stat)
    );

    // Back: walk the head job one nibble step per cycle, while out_ready allows, into the output register
    clnws_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head_job),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .ctrl_byte (ctrl_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // A wait-only step only opens the init script and is never the final step
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.strobe_res |->
            !out_data.last && out_data.wait_us == clnws_pkg::WAIT_POWERUP)
        else $error("wait-only step outside init script");

    // An upper nibble (no wait) always has its lower half after it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.strobe_res && out_data.wait_us == clnws_pkg::WAIT_NONE
            |-> !out_data.last)
        else $error("upper nibble flagged as last step");

    // The front never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("job queue overflow");

    // Popping needs a job at the head
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("job queue underflow");

endmodule

`default_nettype wire

>>> tb/lcd_step_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the config port, predicts LCD steps, compares.
module lcd_step_checker
    import clnws_pkg::*;
#(
    parameter int LINE_WIDTH = LINE_WIDTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  in_item_t          in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  out_item_t         out_data,
    input  logic              cfg_we,
    input  logic [BYTE_W-1:0] cfg_wdata,
    output int                errors,
    output int                pending,
    output int                steps_checked,
    output int                line_wraps,
    output int                string_stops
);

    localparam int COL_BITS = $clog2(LINE_WIDTH + 1);

    out_item_t           lcd_steps[$];
    logic [BYTE_W-1:0]   ctrl_byte;
    logic [COL_BITS-1:0] str_col;
    logic                str_row;
    logic                str_full;
    int                  fails;
    int                  checked;
    int                  wraps;
    int                  stops;

    task automatic add_step(input logic [NIB_W-1:0] nib, input rs_t rs,
                            input logic strobe, input logic [WAIT_W-1:0] us);
        out_item_t s;
        s.nibble     = nib;
        s.reg_select = rs;
        s.strobe_res = strobe;
        s.wait_us    = us;
        s.last       = 1'b0;
        lcd_steps.push_back(s);
    endtask

    // upper nibble first, no wait between the two strobes
    task automatic add_byte(input logic [BYTE_W-1:0] b, input rs_t rs,
                            input logic [WAIT_W-1:0] us);
        add_step(b[7:4], rs, 1'b1, WAIT_NONE);
        add_step(b[3:0], rs, 1'b1, us);
    endtask

    task automatic predict_steps(input in_item_t req);
        int                size_at_start;
        logic [BYTE_W-1:0] row_addr;
        logic              put;
        out_item_t         tail;
        size_at_start = lcd_steps.size();
        case (req.opcode)
            OP_INIT: begin
                add_step('0, RS_INSTR, 1'b0, WAIT_POWERUP);
                repeat (3) add_step(NIB_WAKE, RS_INSTR, 1'b1, WAIT_CMD);
                add_step(NIB_BUS4, RS_INSTR, 1'b1, WAIT_CMD);
                add_byte(CMD_FUNC_SET, RS_INSTR, WAIT_CMD);
                add_byte(CMD_DISP_OFF, RS_INSTR, WAIT_CMD);
                add_byte(CMD_CLEAR, RS_INSTR, WAIT_CMD);
                add_byte(CMD_ENTRY, RS_INSTR, WAIT_CMD);
                add_byte(ctrl_byte, RS_INSTR, WAIT_CMD);
            end
            OP_CMD:  add_byte(req.value, RS_INSTR, WAIT_CMD);
            OP_DATA: add_byte(req.value, RS_DATA, WAIT_DATA);
            OP_CURSOR: begin
                if (req.column < LINE_WIDTH) begin
                    case (req.row)
                        2'd1:    row_addr = ROW1_BITS;
                        2'd2:    row_addr = ROW2_BITS;
                        2'd3:    row_addr = ROW3_BITS;
                        default: row_addr = '0;
                    endcase
                    add_byte(CMD_SET_DDRAM | {3'b000, req.column} | row_addr,
                             RS_INSTR, WAIT_CMD);
                end
            end
            OP_STRING: begin
                if (req.first_of_string) begin
                    str_col  = '0;
                    str_row  = 1'b0;
                    str_full = 1'b0;
                    add_byte(CMD_SET_DDRAM, RS_INSTR, WAIT_CMD);
                end
                if (!str_full) begin
                    put = 1'b1;
                    if (str_col >= LINE_WIDTH) begin
                        if (!str_row) begin
                            add_byte(CMD_LINE2, RS_INSTR, WAIT_CMD);
                            str_row = 1'b1;
                            str_col = '0;
                            wraps++;
                        end else begin
                            str_full = 1'b1;
                            put      = 1'b0;
                            stops++;
                        end
                    end
                    if (put) begin
                        add_byte(req.value, RS_DATA, WAIT_DATA);
                        str_col = str_col + 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (lcd_steps.size() > size_at_start) begin
            tail      = lcd_steps.pop_back();
            tail.last = 1'b1;
            lcd_steps.push_back(tail);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        out_item_t want;
        logic      bad;
        if (!rst_n) begin
            ctrl_byte = CTRL_RESET;
            str_col   = '0;
            str_row   = 1'b0;
            str_full  = 1'b0;
            lcd_steps.delete();
        end else begin
            if (cfg_we)
                ctrl_byte = cfg_wdata;
            if (in_valid && in_ready)
                predict_steps(in_data);
            if (out_valid && out_ready) begin
                if (lcd_steps.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected step nib=%h rs=%b en=%b wait=%0d last=%b",
                                 $time, out_data.nibble, out_data.reg_select,
                                 out_data.strobe_res, out_data.wait_us, out_data.last);
                end else begin
                    want = lcd_steps.pop_front();
                    checked++;
                    bad = (out_data.nibble     !== want.nibble)     ||
                          (out_data.reg_select !== want.reg_select) ||
                          (out_data.strobe_res !== want.strobe_res) ||
                          (out_data.wait_us    !== want.wait_us)    ||
                          (out_data.last       !== want.last);
                    if (bad) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("%0t: step %0d wrong", $time, checked);
                            $display("  expected nib=%h rs=%b en=%b wait=%0d last=%b",
                                     want.nibble, want.reg_select, want.strobe_res,
                                     want.wait_us, want.last);
                            $display("  actual   nib=%h rs=%b en=%b wait=%0d last=%b",
                                     out_data.nibble, out_data.reg_select,
                                     out_data.strobe_res, out_data.wait_us, out_data.last);
                        end
                    end
                end
            end
        end
        errors        <= fails;
        pending       <= lcd_steps.size();
        steps_checked <= checked;
        line_wraps    <= wraps;
        string_stops  <= stops;
    end

endmodule

>>> tb/char_lcd_nibble_write_sequencer_test.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the LCD nibble sequencer. All prediction and
// comparison lives in lcd_step_checker; this module only makes traffic.
module char_lcd_nibble_write_sequencer_test;
    import clnws_pkg::*;

    localparam int PHASES        = 5;
    localparam int PHASE_QUOTA   = 60;     // counted requests per random phase
    localparam int SETTLE_CYCLES = 40;     // covers requests that make no steps
    localparam int CYCLE_LIMIT   = 400000;

    // opcodes the block must ignore
    localparam logic [OPCODE_W-1:0] OP_UNDEF_LO = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_UNDEF_HI = 3'd7;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    in_item_t          in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    out_item_t         out_data;
    logic              cfg_we    = 1'b0;
    logic [BYTE_W-1:0] cfg_wdata = '0;

    int errors;
    int pending;
    int steps_checked;
    int line_wraps;
    int string_stops;

    // idle odds in percent, changed per phase
    int gap_pct       = 0;
    int stall_pct     = 0;
    int requests_sent = 0;
    int init_count    = 0;
    int cycle_count   = 0;

    char_lcd_nibble_write_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    lcd_step_checker step_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .errors        (errors),
        .pending       (pending),
        .steps_checked (steps_checked),
        .line_wraps    (line_wraps),
        .string_stops  (string_stops)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Watchdog: a hung handshake or a missing step ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d steps still owed", CYCLE_LIMIT, pending);
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver back-pressure: random stall bursts. With stall_pct at zero
    // ready stays high the whole time.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    function automatic in_item_t make_request(input logic [OPCODE_W-1:0] op,
                                              input logic [BYTE_W-1:0] value,
                                              input logic [COLUMN_W-1:0] column,
                                              input logic [ROW_W-1:0] row,
                                              input logic first);
        in_item_t req;
        req.opcode          = op;
        req.value           = value;
        req.column          = column;
        req.row             = row;
        req.first_of_string = first;
        return req;
    endfunction

    // Mixed single request; most cursor columns land on the visible line,
    // a quarter fall off the end and must produce nothing.
    function automatic in_item_t random_request();
        in_item_t req;
        int       pick;
        pick                = $urandom_range(0, 99);
        req.value           = BYTE_W'($urandom_range(0, 255));
        req.row             = ROW_W'($urandom_range(0, 3));
        req.first_of_string = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0)
            req.column = COLUMN_W'($urandom_range(16, 31));
        else
            req.column = COLUMN_W'($urandom_range(0, 15));
        if (pick < 8)
            req.opcode = OP_INIT;
        else if (pick < 28)
            req.opcode = OP_CMD;
        else if (pick < 50)
            req.opcode = OP_DATA;
        else if (pick < 72)
            req.opcode = OP_CURSOR;
        else if (pick < 94)
            req.opcode = OP_STRING;
        else
            req.opcode = OPCODE_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        return req;
    endfunction

    // Present one transaction and hold it until accepted. Valid is only
    // dropped for a gap, so back-to-back transactions keep it high.
    task automatic offer_request(input in_item_t req);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        // ignored opcodes do not count toward the phase quota
        if (req.opcode <= OP_STRING)
            requests_sent++;
        if (req.opcode == OP_INIT)
            init_count++;
    endtask

    // Stop sending and wait for every owed step, then let any request
    // that makes no steps work its way through.
    task automatic drain_requests();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called with the block idle.
    task automatic set_display_control(input logic [BYTE_W-1:0] ctrl);
        cfg_we    <= 1'b1;
        cfg_wdata <= ctrl;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly well-formed strings (first char flagged, then up to 39 more)
    // so line wrap and the full-display stop get hit; the rest is a mix of
    // single requests, stray string chars and ignored opcodes.
    task automatic random_phase(input int gap, input int stall);
        int       start;
        int       length;
        logic     paused;
        in_item_t req;
        gap_pct   = gap;
        stall_pct = stall;
        start     = requests_sent;
        paused    = 1'b0;
        while (requests_sent - start < PHASE_QUOTA)
        begin
            // sender holds off mid-phase until the block has caught up
            if (!paused && requests_sent - start >= PHASE_QUOTA / 2)
            begin
                drain_requests();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 55)
            begin
                length = $urandom_range(1, 40);
                for (int k = 0; k < length; k++)
                begin
                    req                 = random_request();
                    req.opcode          = OP_STRING;
                    req.first_of_string = (k == 0);
                    offer_request(req);
                end
            end
            else
            begin
                offer_request(random_request());
            end
        end
        drain_requests();
    endtask

    initial
    begin
        logic [BYTE_W-1:0] ctrl;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass, display control still at its reset value.
        gap_pct   = 20;
        stall_pct = 20;
        // string char straight out of reset continues from home
        offer_request(make_request(OP_STRING, 8'h41, 5'd0, 2'd0, 1'b0));
        offer_request(make_request(OP_INIT, 8'h00, 5'd0, 2'd0, 1'b0));
        offer_request(make_request(OP_CMD, 8'h00, 5'd0, 2'd0, 1'b0));
        offer_request(make_request(OP_CMD, 8'hFF, 5'd31, 2'd3, 1'b1));
        offer_request(make_request(OP_DATA, 8'h00, 5'd0, 2'd0, 1'b0));
        offer_request(make_request(OP_DATA, 8'hFF, 5'd31, 2'd3, 1'b1));
        offer_request(make_request(OP_DATA, 8'h5A, 5'd10, 2'd1, 1'b0));
        // cursor: every row selector, both column edges, off-screen columns
        offer_request(make_request(OP_CURSOR, 8'h00, 5'd0, 2'd0, 1'b0));
        offer_request(make_request(OP_CURSOR, 8'hFF, 5'd15, 2'd1, 1'b0));
        offer_request(make_request(OP_CURSOR, 8'h00, 5'd9, 2'd2, 1'b1));
        offer_request(make_request(OP_CURSOR, 8'h00, 5'd4, 2'd3, 1'b0));
        offer_request(make_request(OP_CURSOR, 8'h00, 5'd16, 2'd1, 1'b0));
        offer_request(make_request(OP_CURSOR, 8'h00, 5'd31, 2'd3, 1'b0));
        // ignored opcodes, including one with every other bit set
        offer_request(make_request(OP_UNDEF_LO, 8'h00, 5'd0, 2'd0, 1'b0));
        offer_request(make_request(OP_UNDEF_HI, 8'hFF, 5'd31, 2'd3, 1'b1));
        // string restart, a zero character, restart in mid-string
        offer_request(make_request(OP_STRING, 8'h48, 5'd0, 2'd0, 1'b1));
        offer_request(make_request(OP_STRING, 8'h00, 5'd0, 2'd0, 1'b0));
        offer_request(make_request(OP_STRING, 8'hFF, 5'd31, 2'd3, 1'b1));
        offer_request(make_request(OP_CMD, 8'hA5, 5'd0, 2'd0, 1'b0));
        offer_request(make_request(OP_INIT, 8'hFF, 5'd31, 2'd3, 1'b1));
        drain_requests();

        // Random phases, each under its own display control setting.
        // Phase 2 and the final phase run with no idling at all.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       ctrl = 8'h00;
                1:       ctrl = 8'hFF;
                4:       ctrl = 8'h0F;
                default: ctrl = BYTE_W'($urandom_range(0, 255));
            endcase
            set_display_control(ctrl);
            case (p)
                0:       random_phase(25, 25);
                1:       random_phase(10, 50);
                3:       random_phase(50, 10);
                default: random_phase(0, 0);
            endcase
        end

        $display("Run covered %0d requests (%0d init) over %0d control settings, %0d steps.",
                 requests_sent, init_count, PHASES + 1, steps_checked);
        $display("Strings wrapped to line two %0d times and hit the end of line two %0d times.",
                 line_wraps, string_stops);
        if (errors == 0 && pending == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
